[hdl/clef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clef_pkg
// Shared types and constants of the console line echo framer.
// ----------------------------------------------------------------------------
package clef_pkg;

   localparam int unsigned IDLE_W          = 20;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 20'd100000;
   localparam int unsigned HEAD_LEN        = 13;
   localparam int unsigned TAIL_LEN        = 4;
   localparam logic [7:0]  CH_CR           = 8'h0D;
   localparam logic [7:0]  CH_LF           = 8'h0A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_HEAD,
      ST_BODY,
      ST_TAIL
   } state_type;

   typedef enum logic [1:0] {
      SRC_ECHO,
      SRC_HEAD,
      SRC_BODY,
      SRC_TAIL
   } src_type;

   typedef struct packed {
      logic    in_ready;
      logic    emit;
      src_type src;
      logic    last;
      logic    cnt_clr;
      logic    cnt_inc;
      logic    len_clr;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_tick;
      logic dispatch_hit;
      logic item_lf;
      logic out_free;
      logic head_end;
      logic body_end;
      logic tail_end;
      logic len_zero;
   } sts_type;

   function automatic logic [7:0] head_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = CH_CR;
         4'd1:    ch = CH_LF;
         4'd2:    ch = "u";
         4'd3:    ch = "a";
         4'd4:    ch = "r";
         4'd5:    ch = "t";
         4'd6:    ch = " ";
         4'd7:    ch = "e";
         4'd8:    ch = "c";
         4'd9:    ch = "h";
         4'd10:   ch = "o";
         4'd11:   ch = ">";
         4'd12:   ch = " ";
         default: ch = " ";
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] tail_char(input logic idx_lsb);
      return idx_lsb ? CH_LF : CH_CR;
   endfunction

endpackage
`default_nettype wire

[hdl/clef_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clef_ifs
// Valid/ready channels for received items and transmitted characters.
// ----------------------------------------------------------------------------
interface clef_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface clef_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last;

   modport source (output valid, output tx_byte, output last, input ready);
   modport sink   (input valid, input tx_byte, input last, output ready);
endinterface
`default_nettype wire

[hdl/clef_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clef_ctrl
// Sequencer: item intake, echo, and dispatch header/body/trailer.
// ----------------------------------------------------------------------------
module clef_ctrl
   import clef_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.src     = SRC_ECHO;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (sts.req_valid) begin
               if (!sts.req_tick) begin
                  state_in = ST_ECHO;
               end else if (sts.dispatch_hit) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_HEAD;
               end
            end
         end
         ST_ECHO: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_ECHO;
               cmd.last = !sts.item_lf;
               cmd.cnt_clr = 1'b1;
               state_in = sts.item_lf ? ST_HEAD : ST_IDLE;
            end
         end
         ST_HEAD: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_HEAD;
               if (sts.head_end) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = sts.len_zero ? ST_TAIL : ST_BODY;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         ST_BODY: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_BODY;
               if (sts.body_end) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_TAIL;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_TAIL;
               if (sts.tail_end) begin
                  cmd.last    = 1'b1;
                  cmd.cnt_clr = 1'b1;
                  cmd.len_clr = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/clef_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clef_dpath
// Line store, length and idle counters, character counter, output register.
// ----------------------------------------------------------------------------
module clef_dpath
   import clef_pkg::*;
#(
   parameter int unsigned BUF_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [IDLE_W-1:0] csr_wr_data,
   clef_req_if.sink               req_ch,
   clef_rsp_if.source             rsp_ch,
   input  wire cmd_type           cmd,
   output sts_type                sts
);

   localparam int unsigned LEN_W = $clog2(BUF_DEPTH);
   localparam int unsigned CNT_W = (LEN_W > 4) ? LEN_W : 4;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUF_DEPTH - 1);

   logic [7:0]        line_mem_ff [BUF_DEPTH];
   logic [LEN_W-1:0]  len_ff,  len_in;
   logic [LEN_W-1:0]  lt_ff,   lt_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic [IDLE_W-1:0] limit_ff;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [7:0]        item_ff;
   logic              item_lf_ff;
   logic [7:0]        body_byte_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              tick_match;
   logic [IDLE_W-1:0] idle_inc;
   logic              hit;
   logic              append;
   logic [7:0]        out_byte;

   assign accept     = cmd.in_ready && req_ch.valid;
   assign tick_match = (len_ff != '0) && (len_ff == lt_ff);
   assign idle_inc   = idle_ff + 1'b1;
   assign hit        = tick_match && (idle_inc >= limit_ff);
   assign append     = accept && !req_ch.op && (req_ch.rx_byte != CH_LF)
                       && (req_ch.rx_byte != CH_CR) && (len_ff < LEN_MAX);

   assign req_ch.ready   = cmd.in_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.tx_byte = rsp_byte_ff;
   assign rsp_ch.last    = rsp_last_ff;

   always_comb begin
      sts              = '0;
      sts.req_valid    = req_ch.valid;
      sts.req_tick     = req_ch.op;
      sts.dispatch_hit = hit;
      sts.item_lf      = item_lf_ff;
      sts.out_free     = !rsp_valid_ff || rsp_ch.ready;
      sts.head_end     = (cnt_ff == CNT_W'(HEAD_LEN - 1));
      sts.body_end     = (cnt_ff[LEN_W-1:0] == LEN_W'(len_ff - 1'b1));
      sts.tail_end     = (cnt_ff == CNT_W'(TAIL_LEN - 1));
      sts.len_zero     = (len_ff == '0);
   end

   always_comb begin
      len_in  = len_ff;
      lt_in   = lt_ff;
      idle_in = idle_ff;
      if (accept) begin
         if (!req_ch.op) begin
            idle_in = '0;
            if (append) begin
               len_in = len_ff + 1'b1;
            end
         end else begin
            if (tick_match) begin
               idle_in = hit ? '0 : idle_inc;
            end
            lt_in = hit ? '0 : len_ff;
         end
      end
      if (cmd.len_clr) begin
         len_in = '0;
      end
   end

   always_comb begin
      priority if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_comb begin
      unique case (cmd.src)
         SRC_ECHO: out_byte = item_ff;
         SRC_HEAD: out_byte = head_char(cnt_ff[3:0]);
         SRC_BODY: out_byte = body_byte_ff;
         SRC_TAIL: out_byte = tail_char(cnt_ff[0]);
         default:  out_byte = item_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         lt_ff        <= '0;
         idle_ff      <= '0;
         limit_ff     <= IDLE_LIMIT_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         lt_ff   <= lt_in;
         idle_ff <= idle_in;
         cnt_ff  <= cnt_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // read one entry ahead: the next counter value addresses the store
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff    <= req_ch.rx_byte;
         item_lf_ff <= (req_ch.rx_byte == CH_LF);
      end
      if (append) begin
         line_mem_ff[len_ff] <= req_ch.rx_byte;
      end
      body_byte_ff <= line_mem_ff[cnt_in[LEN_W-1:0]];
      if (cmd.emit) begin
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= cmd.last;
      end
   end

endmodule
`default_nettype wire

[hdl/console_line_echo_framer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_echo_framer_unit
// Serial console line buffer with echo and idle-timeout dispatch.
//
// req_ch carries one item per transfer: op 0 is a received byte (rx_byte),
// op 1 is an idle tick. rsp_ch carries transmitted characters, one per
// transfer; last marks the final character caused by an item.
// csr_wr_en/csr_wr_data load the 20-bit idle limit (reset value 100000).
// A byte is taken in, then its echo is loaded into the output register.
// A tick without dispatch yields nothing. A dispatch
// (line feed or idle timeout) sends 13 header, length body and 4 trailer
// characters, one per cycle while rsp_ch.ready stays high; the sequencer
// handles one item at a time and the single output register paces the
// characters.
// Reset empties the line and clears the idle counters; no clearing pass.
// When the receiver stalls, the output register holds its character and
// the sequencer waits; req_ch.ready stays low until the item is finished.
// ----------------------------------------------------------------------------
module console_line_echo_framer_unit
   import clef_pkg::*;
#(
   parameter int unsigned BUF_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [IDLE_W-1:0] csr_wr_data,
   clef_req_if.sink               req_ch,
   clef_rsp_if.source             rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   clef_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   clef_dpath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
`default_nettype wire
